FILE: sv/rpd_pkg.sv
// ----------------------------------------------------------------------------
// Rumble packet decoder package
// Shared types, stage numbering and the constant lookup tables.
// ----------------------------------------------------------------------------
package rpd_pkg;

	// Pipeline stage numbering.
	localparam int NSTAGE     = 32;
	localparam int LOG_ITERS  = 24;
	localparam int STG_LOOKUP = 1;
	localparam int STG_SQUARE = 2;
	localparam int STG_PROD   = 3;
	localparam int STG_SUM    = 4;
	localparam int STG_LEAD   = 5;
	localparam int STG_NORM   = 6;
	localparam int STG_ITER0  = 7;
	localparam int STG_MULT   = STG_ITER0 + LOG_ITERS;
	localparam int STG_ROUND  = STG_MULT + 1;

	// Datapath widths.
	localparam int XW = 49;
	localparam int NW = 6;
	localparam int MW = 32;
	localparam int EW = 46;

	localparam logic [8:0]  LA_FLOOR   = 9'h080;
	localparam logic [30:0] LOG10_2_Q  = 31'd1292913987;
	localparam logic [63:0] AMP_DEN_LO = 64'd17 << 31;
	localparam logic [63:0] AMP_DEN_HI = 64'd87 << 31;
	localparam logic [63:0] Q31_HALF   = 64'd1 << 30;
	localparam logic [XW-1:0] ENERGY_ONE = XW'(1) << 19;

	typedef struct packed {
		logic [31:0] left_word;
		logic [31:0] right_word;
	} in_t;

	typedef struct packed {
		logic [13:0] left_low_freq;
		logic [15:0] left_low_amp;
		logic [14:0] left_high_freq;
		logic [15:0] left_high_amp;
		logic [13:0] right_low_freq;
		logic [15:0] right_low_amp;
		logic [14:0] right_high_freq;
		logic [15:0] right_high_amp;
		logic [15:0] magnitude;
	} out_t;

	typedef struct packed {
		logic [13:0] low_freq;
		logic [15:0] low_amp;
		logic [14:0] high_freq;
		logic [15:0] high_amp;
	} lane_fields_t;

	typedef struct packed {
		logic [EW-1:0] e_low;
		logic [EW-1:0] e_high;
	} lane_energy_t;

	typedef logic [63:0] pow_rom_t [128];
	typedef logic [15:0] amp_rom_t [256];
	typedef logic [41:0] lf_rom_t [32];
	typedef logic [42:0] hf_rom_t [128];
	typedef logic [15:0] amp_small_t [16];

	localparam amp_small_t AMP_SMALL = '{
		16'd0, 16'd16, 16'd24, 16'd29, 16'd34, 16'd41, 16'd48, 16'd58,
		16'd68, 16'd81, 16'd97, 16'd115, 16'd137, 16'd163, 16'd194, 16'd230
	};

	// Rounded integer square root, one result bit per step.
	function automatic logic [63:0] sqrt_round(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > v) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		if (v > res) res = res + 64'd1;
		return res;
	endfunction

	function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
		return (a * b + Q31_HALF) >> 31;
	endfunction

	// 2^(j/128) in Q31, built from repeated square roots of two.
	function automatic pow_rom_t pow_table();
		pow_rom_t tab;
		logic [63:0] root [8];
		logic [63:0] p;
		root[0] = 64'd1 << 32;
		for (int t = 1; t < 8; t++) root[t] = sqrt_round(root[t-1] << 31);
		for (int j = 0; j < 128; j++) begin
			p = 64'd1 << 31;
			for (int b = 0; b < 7; b++) begin
				if (((j >> b) & 1) != 0) p = mul_q31(p, root[7-b]);
			end
			tab[j] = p;
		end
		return tab;
	endfunction

	function automatic amp_rom_t amp_table();
		amp_rom_t tab;
		pow_rom_t pw;
		logic [63:0] num;
		logic [63:0] q;
		pw = pow_table();
		for (int a = 0; a < 256; a++) begin
			if (a < 16) begin
				tab[a] = AMP_SMALL[a];
			end else if (a < 32) begin
				num = pw[(a - 16) * 8] << 12;
				q = (num + AMP_DEN_LO / 2) / AMP_DEN_LO;
				tab[a] = q[15:0];
			end else begin
				num = (pw[(a % 32) * 4] * 64'd10) << (11 + (a / 32));
				q = (num + AMP_DEN_HI / 2) / AMP_DEN_HI;
				tab[a] = q[15:0];
			end
		end
		return tab;
	endfunction

	function automatic lf_rom_t lf_table();
		lf_rom_t tab;
		pow_rom_t pw;
		logic [63:0] t;
		pw = pow_table();
		for (int i = 0; i < 32; i++) begin
			t = 64'd640 * pw[i * 4];
			tab[i] = t[41:0];
		end
		return tab;
	endfunction

	function automatic hf_rom_t hf_table();
		hf_rom_t tab;
		pow_rom_t pw;
		logic [63:0] t;
		pw = pow_table();
		for (int i = 0; i < 128; i++) begin
			t = 64'd1280 * pw[i];
			tab[i] = t[42:0];
		end
		return tab;
	endfunction

	localparam amp_rom_t AMP_ROM = amp_table();
	localparam lf_rom_t  LF_ROM  = lf_table();
	localparam hf_rom_t  HF_ROM  = hf_table();

endpackage

FILE: sv/rumble_packet_decoder.sv
// ----------------------------------------------------------------------------
// Rumble packet decoder
// Decodes left and right rumble words into amplitudes, frequencies and a
// log10 energy magnitude.
// ----------------------------------------------------------------------------
// Usage:
// A packet transaction (pkt_valid/pkt_ready) carries the left and right rumble
// words. Each produces exactly one result transaction (res_valid/res_ready)
// with the decoded band frequencies and amplitudes of both words and the
// magnitude log10(energy + 1) in Q4.12.
// Both words are decoded by identical lanes side by side; their energies are
// merged and passed to a log10 unit that resolves one log2 bit per stage.
// Each packet passes lookup, squaring, product, sum, leading-one and normalize
// stages, the 24 squaring stages of the log10 unit, then multiply and rounding stages.
// Throughput is one packet per cycle while pkt_ready is high.
// Each stage loads while it or any later stage has room, so a stalled receiver
// only stops intake once every stage holds a packet; pkt_ready then drops.
// Reset clears all stage valid flags; no results are pending after reset.
// ----------------------------------------------------------------------------
module rumble_packet_decoder
	import rpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_ready,
	input  in_t  pkt,
	output logic res_valid,
	input  logic res_ready,
	output out_t res
);

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;
	lane_fields_t    left_fld;
	lane_fields_t    right_fld;
	lane_energy_t    left_eng;
	lane_energy_t    right_eng;
	lane_fields_t    lfld_q [2:NSTAGE];
	lane_fields_t    rfld_q [2:NSTAGE];
	logic [XW-1:0]   x_s4;
	logic [15:0]     mag;

	// A stage may load when it or any later stage is empty, or the result is taken.
	for (genvar k = 1; k <= NSTAGE; k++) begin : g_en
		assign en[k] = res_ready || !(&vld_q[NSTAGE:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= pkt_valid;
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	rpd_lane u_lane_left (
		.clk    (clk),
		.en     (en),
		.word   (pkt.left_word),
		.fields (left_fld),
		.energy (left_eng)
	);

	rpd_lane u_lane_right (
		.clk    (clk),
		.en     (en),
		.word   (pkt.right_word),
		.fields (right_fld),
		.energy (right_eng)
	);

	// Decoded fields ride alongside the magnitude computation.
	for (genvar k = 2; k <= NSTAGE; k++) begin : g_fld
		if (k == 2) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					lfld_q[k] <= left_fld;
					rfld_q[k] <= right_fld;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					lfld_q[k] <= lfld_q[k-1];
					rfld_q[k] <= rfld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[STG_SUM]) begin
			x_s4 <= XW'(left_eng.e_low) + XW'(left_eng.e_high)
				+ XW'(right_eng.e_low) + XW'(right_eng.e_high) + ENERGY_ONE;
		end
	end

	rpd_log u_log (
		.clk (clk),
		.en  (en),
		.x   (x_s4),
		.mag (mag)
	);

	assign pkt_ready = en[1];
	assign res_valid = vld_q[NSTAGE];

	always_comb begin
		res.left_low_freq   = lfld_q[NSTAGE].low_freq;
		res.left_low_amp    = lfld_q[NSTAGE].low_amp;
		res.left_high_freq  = lfld_q[NSTAGE].high_freq;
		res.left_high_amp   = lfld_q[NSTAGE].high_amp;
		res.right_low_freq  = rfld_q[NSTAGE].low_freq;
		res.right_low_amp   = rfld_q[NSTAGE].low_amp;
		res.right_high_freq = rfld_q[NSTAGE].high_freq;
		res.right_high_amp  = rfld_q[NSTAGE].high_amp;
		res.magnitude       = mag;
	end

endmodule

FILE: sv/rpd_lane.sv
// ----------------------------------------------------------------------------
// Rumble word lane
// Unpacks one rumble word, looks up its four fields and forms band energies.
// ----------------------------------------------------------------------------
module rpd_lane
	import rpd_pkg::*;
(
	input  logic               clk,
	input  logic [NSTAGE:1]    en,
	input  logic [31:0]        word,
	output lane_fields_t       fields,
	output lane_energy_t       energy
);

	logic [6:0]  lf;
	logic [8:0]  hf;
	logic [6:0]  ha;
	logic [8:0]  la9;
	logic [7:0]  la;
	logic [44:0] lf_sum;
	logic [45:0] hf_sum;
	lane_fields_t fld_s1;
	logic [27:0] lf_sq_s2;
	logic [29:0] hf_sq_s2;
	logic [15:0] la_s2;
	logic [15:0] ha_s2;
	lane_energy_t eng_s3;

	always_comb begin
		lf  = word[22:16];
		hf  = word[8:0];
		ha  = word[15:9];
		la9 = {word[31:24], word[23]};
		// Indices below the floor give amplitude zero; the rest wrap to 8 bits.
		la  = (la9 < LA_FLOOR) ? 8'd0 : 8'(la9 - LA_FLOOR);
		lf_sum = ({3'b0, LF_ROM[lf[4:0]]} << lf[6:5]) + 45'(Q31_HALF);
		hf_sum = ({3'b0, HF_ROM[hf[6:0]]} << hf[8:7]) + 46'(Q31_HALF);
	end

	always_ff @(posedge clk) begin
		if (en[STG_LOOKUP]) begin
			fld_s1.low_freq  <= lf_sum[44:31];
			fld_s1.low_amp   <= AMP_ROM[la];
			fld_s1.high_freq <= hf_sum[45:31];
			fld_s1.high_amp  <= AMP_ROM[{1'b0, ha}];
		end
		if (en[STG_SQUARE]) begin
			lf_sq_s2 <= fld_s1.low_freq * fld_s1.low_freq;
			hf_sq_s2 <= fld_s1.high_freq * fld_s1.high_freq;
			la_s2    <= fld_s1.low_amp;
			ha_s2    <= fld_s1.high_amp;
		end
		if (en[STG_PROD]) begin
			eng_s3.e_low  <= EW'(la_s2 * lf_sq_s2);
			eng_s3.e_high <= EW'(ha_s2 * hf_sq_s2);
		end
	end

	assign fields = fld_s1;
	assign energy = eng_s3;

endmodule

FILE: sv/rpd_log.sv
// ----------------------------------------------------------------------------
// Log10 unit
// Normalizes the energy and extracts log2 bits by repeated squaring, one per
// stage, then scales to log10 in Q4.12.
// ----------------------------------------------------------------------------
module rpd_log
	import rpd_pkg::*;
(
	input  logic            clk,
	input  logic [NSTAGE:1] en,
	input  logic [XW-1:0]   x,
	output logic [15:0]     mag
);

	logic [NW-1:0]    lead;
	logic [XW-1:0]    x_s5;
	logic [NW-1:0]    n_s5;
	logic [XW+30:0]   norm;
	logic [MW-1:0]    m_s6;
	logic [4:0]       e_s6;
	logic [MW-1:0]    it_m_q [LOG_ITERS];
	logic [LOG_ITERS-1:0] it_l_q [LOG_ITERS];
	logic [4:0]       it_e_q [LOG_ITERS];
	logic [59:0]      prod_s31;
	logic [60:0]      rnd;
	logic [15:0]      mag_s32;

	always_comb begin
		lead = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) lead = NW'(i);
		end
	end

	assign norm = {x_s5, 31'b0} >> n_s5;

	always_ff @(posedge clk) begin
		if (en[STG_LEAD]) begin
			x_s5 <= x;
			n_s5 <= lead;
		end
		if (en[STG_NORM]) begin
			m_s6 <= norm[MW-1:0];
			// The energy always carries the added one, so the exponent is at least 19.
			e_s6 <= 5'(n_s5 - NW'(19));
		end
	end

	for (genvar i = 0; i < LOG_ITERS; i++) begin : g_iter
		logic [MW-1:0]        m_in;
		logic [LOG_ITERS-1:0] l_in;
		logic [4:0]           e_in;
		logic [63:0]          sq;
		if (i == 0) begin : g_first
			assign m_in = m_s6;
			assign l_in = '0;
			assign e_in = e_s6;
		end else begin : g_next
			assign m_in = it_m_q[i-1];
			assign l_in = it_l_q[i-1];
			assign e_in = it_e_q[i-1];
		end
		assign sq = m_in * m_in;
		always_ff @(posedge clk) begin
			if (en[STG_ITER0 + i]) begin
				it_m_q[i] <= sq[63] ? sq[63:32] : sq[62:31];
				it_l_q[i] <= {l_in[LOG_ITERS-2:0], sq[63]};
				it_e_q[i] <= e_in;
			end
		end
	end

	assign rnd = {1'b0, prod_s31} + (61'd1 << 43);

	always_ff @(posedge clk) begin
		if (en[STG_MULT]) begin
			prod_s31 <= {it_e_q[LOG_ITERS-1], it_l_q[LOG_ITERS-1]} * LOG10_2_Q;
		end
		if (en[STG_ROUND]) begin
			mag_s32 <= rnd[59:44];
		end
	end

	assign mag = mag_s32;

endmodule
